### hw/rtl/char_lcd_nibble_sequencer_assert.svh
// ----------------------------------------------------------------------------
// char lcd nibble sequencer assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define CLNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent in the next cycle
`define CLNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/clns_pkg.sv
// ----------------------------------------------------------------------------
// clns_pkg
// types, register codes and the microcode program of the lcd nibble sequencer
// ----------------------------------------------------------------------------
package clns_pkg;

    // request codes
    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_DATA   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_HOME   = 3'd4,
        CMD_CURSOR = 3'd5,
        CMD_GLYPH  = 3'd6
    } t_cmd;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LINE_ONE   = 3'd0,
        CFG_LINE_TWO   = 3'd1,
        CFG_LINE_THREE = 3'd2,
        CFG_LINE_FOUR  = 3'd3,
        CFG_CMD_WAIT   = 3'd4,
        CFG_DATA_WAIT  = 3'd5,
        CFG_CLEAR_WAIT = 3'd6,
        CFG_POWER_WAIT = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [6:0]  line_one_base;
        logic [6:0]  line_two_base;
        logic [6:0]  line_three_base;
        logic [6:0]  line_four_base;
        logic [9:0]  command_wait_us;
        logic [9:0]  data_wait_us;
        logic [13:0] clear_wait_us;
        logic [15:0] power_up_wait_us;
    } t_cfg;

    // nibble source of a step
    typedef enum logic [1:0] {
        N_CONST = 2'd0,
        N_HI    = 2'd1,
        N_LO    = 2'd2
    } t_nsel;

    // hold time of a step
    typedef enum logic [3:0] {
        W_POWER  = 4'd0,
        W_SOFT   = 4'd1,
        W_REPEAT = 4'd2,
        W_FOUR   = 4'd3,
        W_STROBE = 4'd4,
        W_CMD    = 4'd5,
        W_DATA   = 4'd6,
        W_CLEAR  = 4'd7,
        W_HOME   = 4'd8
    } t_wsel;

    localparam int PC_W     = 5;
    localparam int PROG_LEN = 19;

    // routine entry points
    localparam logic [PC_W-1:0] ENT_INIT  = 5'd0;
    localparam logic [PC_W-1:0] ENT_DATA  = 5'd11;
    localparam logic [PC_W-1:0] ENT_CMD   = 5'd13;
    localparam logic [PC_W-1:0] ENT_CLEAR = 5'd15;
    localparam logic [PC_W-1:0] ENT_HOME  = 5'd17;

    localparam logic [7:0] CURSOR_CMD = 8'h80;
    localparam logic [1:0] GLYPH_CMD  = 2'b01;

    typedef struct packed {
        t_nsel           nsel;
        logic [3:0]      nconst;
        logic            strobe;
        t_wsel           wsel;
        logic            last;
        logic            jump;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword mk(input t_nsel nsel, input logic [3:0] nconst,
                                  input logic strobe, input t_wsel wsel,
                                  input logic last, input logic jump,
                                  input logic [PC_W-1:0] target);
        t_uword w;
        w.nsel   = nsel;
        w.nconst = nconst;
        w.strobe = strobe;
        w.wsel   = wsel;
        w.last   = last;
        w.jump   = jump;
        w.target = target;
        return w;
    endfunction

    // microcode program, one transfer per step
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            // init: power-up wait, three soft resets, 4-bit switch
            5'd0:  w = mk(N_CONST, 4'h0, 1'b0, W_POWER,  1'b0, 1'b0, ENT_INIT);
            5'd1:  w = mk(N_CONST, 4'h3, 1'b1, W_SOFT,   1'b0, 1'b0, ENT_INIT);
            5'd2:  w = mk(N_CONST, 4'h3, 1'b1, W_REPEAT, 1'b0, 1'b0, ENT_INIT);
            5'd3:  w = mk(N_CONST, 4'h3, 1'b1, W_REPEAT, 1'b0, 1'b0, ENT_INIT);
            5'd4:  w = mk(N_CONST, 4'h2, 1'b1, W_FOUR,   1'b0, 1'b0, ENT_INIT);
            // function set, display on, entry mode, then into clear
            5'd5:  w = mk(N_CONST, 4'h2, 1'b1, W_STROBE, 1'b0, 1'b0, ENT_INIT);
            5'd6:  w = mk(N_CONST, 4'h8, 1'b1, W_CMD,    1'b0, 1'b0, ENT_INIT);
            5'd7:  w = mk(N_CONST, 4'h0, 1'b1, W_STROBE, 1'b0, 1'b0, ENT_INIT);
            5'd8:  w = mk(N_CONST, 4'hC, 1'b1, W_CMD,    1'b0, 1'b0, ENT_INIT);
            5'd9:  w = mk(N_CONST, 4'h0, 1'b1, W_STROBE, 1'b0, 1'b0, ENT_INIT);
            5'd10: w = mk(N_CONST, 4'h6, 1'b1, W_CMD,    1'b0, 1'b1, ENT_CLEAR);
            // data byte
            5'd11: w = mk(N_HI,    4'h0, 1'b1, W_STROBE, 1'b0, 1'b0, ENT_INIT);
            5'd12: w = mk(N_LO,    4'h0, 1'b1, W_DATA,   1'b1, 1'b0, ENT_INIT);
            // command byte
            5'd13: w = mk(N_HI,    4'h0, 1'b1, W_STROBE, 1'b0, 1'b0, ENT_INIT);
            5'd14: w = mk(N_LO,    4'h0, 1'b1, W_CMD,    1'b1, 1'b0, ENT_INIT);
            // clear display
            5'd15: w = mk(N_CONST, 4'h0, 1'b1, W_STROBE, 1'b0, 1'b0, ENT_INIT);
            5'd16: w = mk(N_CONST, 4'h1, 1'b1, W_CLEAR,  1'b1, 1'b0, ENT_INIT);
            // return home
            5'd17: w = mk(N_CONST, 4'h0, 1'b1, W_STROBE, 1'b0, 1'b0, ENT_INIT);
            5'd18: w = mk(N_CONST, 4'h2, 1'b1, W_HOME,   1'b1, 1'b0, ENT_INIT);
            default: w = mk(N_CONST, 4'h0, 1'b0, W_STROBE, 1'b1, 1'b0, ENT_INIT);
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/clns_if.sv
// ----------------------------------------------------------------------------
// clns interfaces
// request and transfer channels of the lcd nibble sequencer
// ----------------------------------------------------------------------------
interface clns_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] value;
    logic [7:0] column;
    logic [2:0] row;
    logic [2:0] glyph;

    modport source (output valid, command, value, column, row, glyph, input ready);
    modport sink   (input valid, command, value, column, row, glyph, output ready);
endinterface

interface clns_out_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [3:0]  nibble;
    logic        strobe_res;
    logic [15:0] wait_us;
    logic        last;

    modport source (output valid, reg_select, nibble, strobe_res, wait_us, last,
                    input ready);
    modport sink   (input valid, reg_select, nibble, strobe_res, wait_us, last,
                    output ready);
endinterface

### hw/rtl/clns_wait.sv
// ----------------------------------------------------------------------------
// clns_wait
// hold time of one transfer: delay plus strobe width (none at power-up), saturated to 16 bits
// ----------------------------------------------------------------------------
module clns_wait
    import clns_pkg::*;
#(
    parameter int SOFT_RESET_WAIT_US   = 5000,
    parameter int RESET_REPEAT_WAIT_US = 1000,
    parameter int FOUR_BIT_WAIT_US     = 5000,
    parameter int HOME_WAIT_US         = 2000,
    parameter int STROBE_WIDTH_US      = 20
) (
    input  t_wsel       i_sel,
    input  t_cfg        i_cfg,
    output logic [15:0] o_wait_us
);

    localparam logic [16:0] L_STROBE = 17'(STROBE_WIDTH_US);
    localparam logic [16:0] L_SOFT   = 17'(SOFT_RESET_WAIT_US);
    localparam logic [16:0] L_REPEAT = 17'(RESET_REPEAT_WAIT_US);
    localparam logic [16:0] L_FOUR   = 17'(FOUR_BIT_WAIT_US);
    localparam logic [16:0] L_HOME   = 17'(HOME_WAIT_US);

    logic [16:0] w_extra;
    logic [16:0] w_sum;
    logic        w_use_strobe;

    always_comb begin
        w_use_strobe = 1'b1;
        unique case (i_sel)
            W_POWER: begin
                w_extra      = {1'b0, i_cfg.power_up_wait_us};
                w_use_strobe = 1'b0;
            end
            W_SOFT:   w_extra = L_SOFT;
            W_REPEAT: w_extra = L_REPEAT;
            W_FOUR:   w_extra = L_FOUR;
            W_STROBE: w_extra = '0;
            W_CMD:    w_extra = 17'(i_cfg.command_wait_us);
            W_DATA:   w_extra = 17'(i_cfg.data_wait_us);
            W_CLEAR:  w_extra = 17'(i_cfg.command_wait_us) + 17'(i_cfg.clear_wait_us);
            W_HOME:   w_extra = 17'(i_cfg.command_wait_us) + L_HOME;
            default:  w_extra = '0;
        endcase
        w_sum     = w_extra + (w_use_strobe ? L_STROBE : 17'd0);
        o_wait_us = w_sum[16] ? 16'hFFFF : w_sum[15:0];
    end

endmodule

### hw/rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// microcoded 4-bit nibble sequencer for an hd44780-style character lcd
// ----------------------------------------------------------------------------
// Each accepted request starts a short routine in a microcode table; every
// step of the routine puts out one nibble transfer (rs level, d4..d7, strobe
// flag, hold time in us, last flag). Steps run at one per cycle while the
// transfer register is free. Each routine but init sends a high and a low
// nibble; init runs its setup steps, then the clear routine. The next
// request is taken in the cycle of the last step, so it can start as the
// last step of the one before fires. Requests with code 7 or a set-cursor
// row outside 1..4 are taken and produce no transfer. Hold times but the
// power-up wait add the strobe width; all saturate at 65535 us. The user
// must write configuration through a plain write port only while the block
// is idle; the block does not enforce this. No clearing pass follows reset.
module char_lcd_nibble_sequencer
    import clns_pkg::*;
#(
    parameter int SOFT_RESET_WAIT_US   = 5000,
    parameter int RESET_REPEAT_WAIT_US = 1000,
    parameter int FOUR_BIT_WAIT_US     = 5000,
    parameter int HOME_WAIT_US         = 2000,
    parameter int STROBE_WIDTH_US      = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    clns_in_if.sink               i_in,
    clns_out_if.source            o_out
);

    // configuration registers
    t_cfg r_cfg;

    // sequencer state
    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [7:0]      r_byte;
    logic            r_rs;

    // transfer register
    logic        r_out_valid;
    logic        r_out_rs;
    logic [3:0]  r_out_nibble;
    logic        r_out_strobe;
    logic [15:0] r_out_wait;
    logic        r_out_last;

    t_uword          w_uw;
    logic            w_adv;
    logic            w_in_ready;
    logic            w_in_fire;
    logic [3:0]      w_nibble;
    logic [15:0]     w_wait;
    logic [PC_W-1:0] w_pc_next;

    // request decode
    logic            w_start;
    logic [PC_W-1:0] w_entry;
    logic [7:0]      w_byte;
    logic            w_rs;
    logic [6:0]      w_base;
    logic            w_row_ok;

    assign w_uw       = ucode(r_pc);
    // a step fires when the transfer register is empty or being drained
    assign w_adv      = r_busy && (!r_out_valid || o_out.ready);
    // take the next request in the cycle of the final step
    assign w_in_ready = !r_busy || (w_adv && w_uw.last);
    assign w_in_fire  = i_in.valid && w_in_ready;
    assign w_pc_next  = w_uw.jump ? w_uw.target : r_pc + 1'b1;

    always_comb begin
        case (w_uw.nsel)
            N_HI:    w_nibble = r_byte[7:4];
            N_LO:    w_nibble = r_byte[3:0];
            default: w_nibble = w_uw.nconst;
        endcase
    end

    clns_wait #(
        .SOFT_RESET_WAIT_US   (SOFT_RESET_WAIT_US),
        .RESET_REPEAT_WAIT_US (RESET_REPEAT_WAIT_US),
        .FOUR_BIT_WAIT_US     (FOUR_BIT_WAIT_US),
        .HOME_WAIT_US         (HOME_WAIT_US),
        .STROBE_WIDTH_US      (STROBE_WIDTH_US)
    ) u_wait (
        .i_sel     (w_uw.wsel),
        .i_cfg     (r_cfg),
        .o_wait_us (w_wait)
    );

    // row base for set cursor
    always_comb begin
        w_row_ok = 1'b1;
        case (i_in.row)
            3'd1:    w_base = r_cfg.line_one_base;
            3'd2:    w_base = r_cfg.line_two_base;
            3'd3:    w_base = r_cfg.line_three_base;
            3'd4:    w_base = r_cfg.line_four_base;
            default: begin
                w_base   = '0;
                w_row_ok = 1'b0;
            end
        endcase
    end

    // dispatch: pick the routine entry and the byte it sends
    always_comb begin
        w_start = 1'b1;
        w_entry = ENT_CMD;
        w_byte  = i_in.value;
        w_rs    = 1'b0;
        unique case (i_in.command)
            CMD_INIT:   w_entry = ENT_INIT;
            CMD_DATA: begin
                w_entry = ENT_DATA;
                w_rs    = 1'b1;
            end
            CMD_WRITE:  w_entry = ENT_CMD;
            CMD_CLEAR:  w_entry = ENT_CLEAR;
            CMD_HOME:   w_entry = ENT_HOME;
            CMD_CURSOR: begin
                // address wraps at 8 bits
                w_byte  = CURSOR_CMD + {1'b0, w_base} + i_in.column;
                w_start = w_row_ok;
            end
            CMD_GLYPH:  w_byte = {GLYPH_CMD, i_in.glyph, 3'b000};
            default:    w_start = 1'b0;   // unused code, no transfer
        endcase
    end

    // sequencer; a new request overrides the step that ends the routine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ENT_INIT;
        end else if (w_in_fire) begin
            r_busy <= w_start;
            r_pc   <= w_entry;
        end else if (w_adv) begin
            r_pc <= w_pc_next;
            if (w_uw.last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_byte <= w_byte;
            r_rs   <= w_rs;
        end
    end

    // transfer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rs     <= r_rs;
            r_out_nibble <= w_nibble;
            r_out_strobe <= w_uw.strobe;
            r_out_wait   <= w_wait;
            r_out_last   <= w_uw.last;
        end
    end

    // configuration writes keep each register's own low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_one_base    <= 7'd0;
            r_cfg.line_two_base    <= 7'd64;
            r_cfg.line_three_base  <= 7'd16;
            r_cfg.line_four_base   <= 7'd80;
            r_cfg.command_wait_us  <= 10'd42;
            r_cfg.data_wait_us     <= 10'd46;
            r_cfg.clear_wait_us    <= 14'd2000;
            r_cfg.power_up_wait_us <= 16'd15000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LINE_ONE:   r_cfg.line_one_base    <= i_cfg_data[6:0];
                CFG_LINE_TWO:   r_cfg.line_two_base    <= i_cfg_data[6:0];
                CFG_LINE_THREE: r_cfg.line_three_base  <= i_cfg_data[6:0];
                CFG_LINE_FOUR:  r_cfg.line_four_base   <= i_cfg_data[6:0];
                CFG_CMD_WAIT:   r_cfg.command_wait_us  <= i_cfg_data[9:0];
                CFG_DATA_WAIT:  r_cfg.data_wait_us     <= i_cfg_data[9:0];
                CFG_CLEAR_WAIT: r_cfg.clear_wait_us    <= i_cfg_data[13:0];
                CFG_POWER_WAIT: r_cfg.power_up_wait_us <= i_cfg_data;
            endcase
        end
    end

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.reg_select = r_out_rs;
    assign o_out.nibble     = r_out_nibble;
    assign o_out.strobe_res = r_out_strobe;
    assign o_out.wait_us    = r_out_wait;
    assign o_out.last       = r_out_last;

    `include "char_lcd_nibble_sequencer_assert.svh"

    // a request is only taken when no routine is left mid-way
    `CLNS_ASSERT_NOW(a_accept_idle, w_in_fire, !r_busy || (w_adv && w_uw.last), "request taken while routine running")
    // the final step ends the routine unless a new request starts
    `CLNS_ASSERT_NEXT(a_last_ends, w_adv && w_uw.last && !w_in_fire, !r_busy, "routine ran past its last step")
    // the step counter stays inside the program
    `CLNS_ASSERT_NOW(a_pc_range, r_busy, r_pc < PC_W'(PROG_LEN), "step counter outside program")

endmodule
